>>> src/ea2rm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ea2rm_pkg: shared constants for the Euler-angle rotation matrix core
// Widths, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package ea2rm_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int COEF_BITS  = 16;
  localparam int FRAC       = COEF_BITS - 1;
  localparam int ITERS      = COEF_BITS;
  localparam int CW         = 34;
  localparam int ZW         = 34;
  localparam int SH         = 30 - FRAC;
  localparam int PW         = 2 * COEF_BITS + 2;
  localparam int SW         = COEF_BITS + 3;

  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

  typedef logic signed [COEF_BITS-1:0] coef_t;
  // A product of two full-scale negative values reaches +1, so products
  // carry one extra integer bit.
  typedef logic signed [COEF_BITS:0]   prod_t;
  typedef logic signed [CW-1:0]        cval_t;
  typedef logic signed [ZW-1:0]        zval_t;
  typedef logic signed [SW-1:0]        sum_t;

  typedef struct packed {
    logic cmd;
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
  } in_item_t;

  typedef struct packed {
    coef_t sp;
    coef_t cp;
    coef_t st;
    coef_t ct;
    coef_t ss;
    coef_t cs;
  } trig_t;

  function automatic logic [31:0] atan_val(input int i);
    logic [31:0] t [0:31];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
          32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
          32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
          32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
          32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
          32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
          32'h00000000, 32'h00000000};
    return t[i];
  endfunction

  function automatic prod_t ext(input coef_t v);
    return prod_t'(v);
  endfunction

  // Q1.F product rounded half up.
  function automatic prod_t mulq(input prod_t a, input prod_t b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + (PW'(1) <<< (FRAC - 1));
    return prod_t'(p >>> FRAC);
  endfunction

endpackage

>>> src/ea2rm_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ea2rm_cordic: pipelined sine/cosine
// Quadrant fold, one CORDIC iteration per stage, then rounding and clamp.
// ----------------------------------------------------------------------------
module ea2rm_cordic (
  input  logic                   clk,
  input  logic                   en,
  input  logic [15:0]            angle,
  output ea2rm_pkg::coef_t       sin_o,
  output ea2rm_pkg::coef_t       cos_o
);

  localparam int N = ea2rm_pkg::ITERS;

  ea2rm_pkg::cval_t x_r [0:N];
  ea2rm_pkg::cval_t y_r [0:N];
  ea2rm_pkg::zval_t z_r [0:N];
  logic             f_r [0:N];
  ea2rm_pkg::coef_t sin_r, cos_r;

  logic [31:0] p, keep, pf;
  logic        flip;

  always_comb begin
    keep = 32'hFFFFFFFF << (32 - ea2rm_pkg::ANGLE_BITS);
    p    = {angle, 16'h0} & keep;
    flip = p[31] ^ p[30];
    pf   = flip ? (p - 32'h80000000) : p;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= ea2rm_pkg::CORDIC_K;
      y_r[0] <= '0;
      z_r[0] <= ea2rm_pkg::ZW'($signed(pf));
      f_r[0] <= flip;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    ea2rm_pkg::cval_t xs, ys;
    ea2rm_pkg::zval_t at;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    assign at = ea2rm_pkg::ZW'(ea2rm_pkg::atan_val(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][ea2rm_pkg::ZW-1]) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + at;
        end
        f_r[i+1] <= f_r[i];
      end
    end
  end

  function automatic ea2rm_pkg::coef_t rnd(input ea2rm_pkg::cval_t v, input logic neg);
    ea2rm_pkg::cval_t a, r;
    ea2rm_pkg::cval_t top;
    a   = neg ? -v : v;
    r   = (a + ea2rm_pkg::CW'(1 <<< (ea2rm_pkg::SH - 1))) >>> ea2rm_pkg::SH;
    top = ea2rm_pkg::CW'(1 <<< ea2rm_pkg::FRAC);
    if (r > top - 1) return ea2rm_pkg::coef_t'(top - 1);
    if (r < -top) return ea2rm_pkg::coef_t'(-top);
    return ea2rm_pkg::coef_t'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= rnd(x_r[N], f_r[N]);
      sin_r <= rnd(y_r[N], f_r[N]);
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

>>> src/ea2rm_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ea2rm_matrix: rotation matrix products
// Three register stages: two-factor products, three-factor products, sums
// with optional transpose and Q1.15 conversion.
// ----------------------------------------------------------------------------
module ea2rm_matrix (
  input  logic              clk,
  input  logic              en,
  input  logic              cmd,
  input  ea2rm_pkg::trig_t  trig,
  output logic [143:0]      mat
);

  localparam int F      = ea2rm_pkg::FRAC;
  localparam int RND_SH = (F > 15) ? F - 16 : 0;

  ea2rm_pkg::prod_t spst_r, cpst_r, spct_r, cpct_r, ssct_r, cpcs_r;
  ea2rm_pkg::prod_t spcs_r, sscp_r, spss_r, cscs_r_dummy;
  ea2rm_pkg::trig_t t1_r;
  logic             c1_r, c2_r;
  ea2rm_pkg::prod_t a_r, b_r, c_r, d_r;
  ea2rm_pkg::prod_t e1_r, e2_r, e3_r, e4_r, e5_r, e6_r, e7_r;
  ea2rm_pkg::prod_t sscp_keep_r, spss_keep_r;
  logic [143:0]     mat_r;

  // Stage 1: two-factor products.
  always_ff @(posedge clk) begin
    if (en) begin
      spst_r <= ea2rm_pkg::mulq(ea2rm_pkg::ext(trig.sp), ea2rm_pkg::ext(trig.st));
      cpst_r <= ea2rm_pkg::mulq(ea2rm_pkg::ext(trig.cp), ea2rm_pkg::ext(trig.st));
      spct_r <= ea2rm_pkg::mulq(ea2rm_pkg::ext(trig.sp), ea2rm_pkg::ext(trig.ct));
      cpct_r <= ea2rm_pkg::mulq(ea2rm_pkg::ext(trig.cp), ea2rm_pkg::ext(trig.ct));
      ssct_r <= ea2rm_pkg::mulq(ea2rm_pkg::ext(trig.ss), ea2rm_pkg::ext(trig.ct));
      cpcs_r <= ea2rm_pkg::mulq(ea2rm_pkg::ext(trig.cp), ea2rm_pkg::ext(trig.cs));
      spcs_r <= ea2rm_pkg::mulq(ea2rm_pkg::ext(trig.sp), ea2rm_pkg::ext(trig.cs));
      sscp_r <= ea2rm_pkg::mulq(ea2rm_pkg::ext(trig.ss), ea2rm_pkg::ext(trig.cp));
      spss_r <= ea2rm_pkg::mulq(ea2rm_pkg::ext(trig.sp), ea2rm_pkg::ext(trig.ss));
      cscs_r_dummy <= ea2rm_pkg::mulq(ea2rm_pkg::ext(trig.cs), ea2rm_pkg::ext(trig.ct));
      t1_r   <= trig;
      c1_r   <= cmd;
    end
  end

  // Stage 2: three-factor products; pass the rest along.
  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= ea2rm_pkg::mulq(spst_r, ea2rm_pkg::ext(t1_r.ss));
      b_r  <= ea2rm_pkg::mulq(cpst_r, ea2rm_pkg::ext(t1_r.ss));
      c_r  <= ea2rm_pkg::mulq(spst_r, ea2rm_pkg::ext(t1_r.cs));
      d_r  <= ea2rm_pkg::mulq(cpst_r, ea2rm_pkg::ext(t1_r.cs));
      e1_r <= ea2rm_pkg::ext(t1_r.st);
      e2_r <= spct_r;
      e3_r <= cpct_r;
      e4_r <= ssct_r;
      e5_r <= cpcs_r;
      e6_r <= spcs_r;
      e7_r <= cscs_r_dummy;
      sscp_keep_r <= sscp_r;
      spss_keep_r <= spss_r;
      c2_r <= c1_r;
    end
  end

  function automatic logic [15:0] q15(input ea2rm_pkg::sum_t v);
    ea2rm_pkg::sum_t w;
    if (F > 15) w = (v + ea2rm_pkg::SW'(1 <<< RND_SH)) >>> (F - 15);
    else        w = v <<< (15 - F);
    if (w > 32767)  return 16'h7FFF;
    if (w < -32768) return 16'h8000;
    return w[15:0];
  endfunction

  function automatic ea2rm_pkg::sum_t sx(input ea2rm_pkg::prod_t v);
    return ea2rm_pkg::SW'(v);
  endfunction

  logic [15:0] r [0:8];
  always_comb begin
    r[0] = q15(-sx(e1_r));
    r[1] = q15(sx(e2_r));
    r[2] = q15(sx(e3_r));
    r[3] = q15(-sx(e4_r));
    r[4] = q15(-sx(a_r) - sx(e5_r));
    r[5] = q15(sx(e6_r) - sx(b_r));
    r[6] = q15(sx(e7_r));
    r[7] = q15(sx(c_r) - sx(sscp_keep_r));
    r[8] = q15(sx(spss_keep_r) + sx(d_r));
  end

  // Stage 3: sums, conversion and optional transpose.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        mat_r[16*k +: 16] <= c2_r ? r[(k % 3) * 3 + (k / 3)] : r[k];
      end
    end
  end

  assign mat = mat_r;

endmodule

>>> src/euler_angles_to_rotation_matrix_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_core: Euler angles to rotation matrix
// Streams roll/pitch/yaw in and the nine Q1.15 matrix entries out.
// ----------------------------------------------------------------------------
// One item is accepted per clock while the output is not stalled, and passes
// COEF_BITS + 5 register stages (21 as built): one fold stage, one stage per
// CORDIC iteration, a rounding stage, then three product/sum stages. The whole
// pipeline advances only when the output register is free or being taken, so
// a stall at the output holds every item in place.
module euler_angles_to_rotation_matrix_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // roll_angle, pitch_angle, yaw_angle
  input  logic         in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata   // m11, m12, m13, m21 .. m33
);

  localparam int LAT     = ea2rm_pkg::ITERS + 5;
  localparam int CMD_TAP = ea2rm_pkg::ITERS + 1;

  logic               en;
  logic [LAT-1:0]     vld_r;
  logic [CMD_TAP:0]   cmd_r;
  ea2rm_pkg::trig_t   trig;

  assign en         = !vld_r[LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // cmd is needed at the matrix input, ITERS + 2 stages in.
  always_ff @(posedge clk) begin
    if (en) cmd_r <= {cmd_r[CMD_TAP-1:0], in_tuser};
  end

  ea2rm_cordic u_roll (.clk(clk), .en(en), .angle(in_tdata[15:0]),
                       .sin_o(trig.sp), .cos_o(trig.cp));
  ea2rm_cordic u_pitch (.clk(clk), .en(en), .angle(in_tdata[31:16]),
                        .sin_o(trig.st), .cos_o(trig.ct));
  ea2rm_cordic u_yaw (.clk(clk), .en(en), .angle(in_tdata[47:32]),
                      .sin_o(trig.ss), .cos_o(trig.cs));

  ea2rm_matrix u_mat (.clk(clk), .en(en), .cmd(cmd_r[CMD_TAP]),
                      .trig(trig), .mat(out_tdata));

endmodule
